>>> rtl/dqmm_pkg.sv
// ----------------------------------------------------------------------------
// dqmm_pkg
// Shared codes and widths for the double-ended queue with min/max swap.
// ----------------------------------------------------------------------------
package dqmm_pkg;

  localparam int DATA_W   = 32;
  localparam int MODE_W   = 4;
  localparam int STATUS_W = 2;

  // Operation codes carried on the input tuser
  typedef enum logic [MODE_W-1:0] {
    MODE_PUSH_BACK  = 4'd0,
    MODE_PUSH_FRONT = 4'd1,
    MODE_POP_BACK   = 4'd2,
    MODE_POP_FRONT  = 4'd3,
    MODE_PEEK_FRONT = 4'd4,
    MODE_PEEK_BACK  = 4'd5,
    MODE_SWAP       = 4'd6,
    MODE_CLEAR      = 4'd7,
    MODE_RESIZE     = 4'd8
  } mode_t;

  // Completion codes carried on the output tuser
  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

endpackage

>>> rtl/deque_with_min_max_swap_top.sv
// ----------------------------------------------------------------------------
// deque_with_min_max_swap_top
// Bounded double-ended queue of signed 32-bit values held in a ring store.
//
// Usage:
//   One command enters per transfer on the s_axis channel: the operation code
//   on s_axis_tuser, the value and the resize target on s_axis_tdata. Every
//   command returns exactly one transfer on m_axis: the popped or peeked value
//   and the item count on m_axis_tdata, the completion status on m_axis_tuser.
//   Push, pop, peek, clear and a shrinking resize run as an accept cycle and
//   an execute step: the accept cycle issues the ring store read, then the
//   execute step, once the result register is free, updates the pointers,
//   writes the store and loads the result register.
//   A growing resize moves on to a fill step that appends the value at the
//   back, one store write per appended item.
//   Swap reads the whole queue through the single read port, one item per
//   cycle, then writes the two extremes back.
//   The result register separates the channels, so the next command is taken
//   while a result still waits; if m_axis_tready stays low the block holds in
//   its final step until the result register drains.
//   Reset clears the count, the front pointer and m_axis_tvalid. The store
//   itself is not cleared; entries are only used after they are written.
// ----------------------------------------------------------------------------
module deque_with_min_max_swap_top
  import dqmm_pkg::*;
#(
  parameter int DEPTH = 64,
  localparam int IDX_W = $clog2(DEPTH),
  localparam int CNT_W = $clog2(DEPTH + 1),
  localparam int IN_W  = ((DATA_W + CNT_W + 7) / 8) * 8,
  localparam int OUT_W = ((DATA_W + CNT_W + 7) / 8) * 8
) (
  input  logic                clk,
  input  logic                rst,
  // command channel
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [IN_W-1:0]     s_axis_tdata,   // item_value, new_count, zero pad
  input  logic [MODE_W-1:0]   s_axis_tuser,   // mode
  // result channel
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [OUT_W-1:0]    m_axis_tdata,   // result_value, item_count, zero pad
  output logic [STATUS_W-1:0] m_axis_tuser    // status
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_SCAN,
    S_SWAP_A,
    S_SWAP_B,
    S_FILL
  } state_t;

  localparam logic [CNT_W-1:0] CNT_DEPTH = CNT_W'(DEPTH);
  localparam logic [CNT_W-1:0] CNT_ONE   = CNT_W'(1);
  localparam logic [IDX_W-1:0] IDX_LAST  = IDX_W'(DEPTH - 1);

  // Ring arithmetic: base < DEPTH and ofs <= DEPTH, so one subtract wraps it.
  function automatic logic [IDX_W-1:0] wrap_add(input logic [IDX_W-1:0] base,
                                                input logic [CNT_W-1:0] ofs);
    logic [CNT_W:0] sum;
    sum = (CNT_W+1)'(base) + (CNT_W+1)'(ofs);
    if (sum >= (CNT_W+1)'(DEPTH)) begin
      sum = sum - (CNT_W+1)'(DEPTH);
    end
    return sum[IDX_W-1:0];
  endfunction

  function automatic logic [IDX_W-1:0] inc_idx(input logic [IDX_W-1:0] a);
    return (a == IDX_LAST) ? '0 : a + IDX_W'(1);
  endfunction

  function automatic logic [IDX_W-1:0] dec_idx(input logic [IDX_W-1:0] a);
    return (a == '0) ? IDX_LAST : a - IDX_W'(1);
  endfunction

  state_t                    state;
  logic [IDX_W-1:0]          front;
  logic [CNT_W-1:0]          cnt;

  // captured command
  logic [MODE_W-1:0]         cmd_mode;
  logic [DATA_W-1:0]         cmd_value;
  logic [CNT_W-1:0]          cmd_target;

  // result register
  logic [DATA_W-1:0]         out_value;
  status_t                   out_status;
  logic [CNT_W-1:0]          out_count;

  // swap scan
  logic [IDX_W-1:0]          issue_addr;
  logic [CNT_W-1:0]          issue_left;
  logic                      data_vld;
  logic [IDX_W-1:0]          data_addr;
  logic                      first;
  logic signed [DATA_W-1:0]  min_val;
  logic signed [DATA_W-1:0]  max_val;
  logic [IDX_W-1:0]          min_addr;
  logic [IDX_W-1:0]          max_addr;

  // store port
  logic                      mem_we;
  logic [IDX_W-1:0]          mem_waddr;
  logic [DATA_W-1:0]         mem_wdata;
  logic                      mem_re;
  logic [IDX_W-1:0]          mem_raddr;
  logic [DATA_W-1:0]         rd_data;

  // derived pointers
  logic [IDX_W-1:0]          tail;
  logic [IDX_W-1:0]          last_addr;
  logic [IDX_W-1:0]          prev_front;
  logic [IDX_W-1:0]          next_front;
  logic [CNT_W-1:0]          drop;
  logic                      is_full;
  logic                      is_empty;
  logic                      accept;
  logic                      out_free;

  assign tail       = wrap_add(front, cnt);
  assign last_addr  = dec_idx(tail);
  assign prev_front = dec_idx(front);
  assign next_front = inc_idx(front);
  assign drop       = cnt - cmd_target;
  assign is_full    = (cnt == CNT_DEPTH);
  assign is_empty   = (cnt == '0);

  assign s_axis_tready = (state == S_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  // result register can take a new result this cycle
  assign out_free      = !m_axis_tvalid || m_axis_tready;

  // Store reads: the end a pop or peek needs is read at accept time, so the
  // data is waiting in the next cycle. During a swap the scan owns the port.
  // Writes never overlap a pending read of the same command, so no forwarding.
  always_comb begin
    mem_raddr = front;
    if (state == S_SCAN) begin
      mem_raddr = issue_addr;
    end else begin
      case (s_axis_tuser) inside
        MODE_POP_BACK, MODE_PEEK_BACK: mem_raddr = last_addr;
        default:                       mem_raddr = front;
      endcase
    end
  end

  assign mem_re = accept || ((state == S_SCAN) && (issue_left != '0));

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = tail;
    mem_wdata = cmd_value;
    unique case (state)
      S_EXEC: begin
        if (out_free && !is_full) begin
          if (cmd_mode == MODE_PUSH_BACK) begin
            mem_we = 1'b1;
          end else if (cmd_mode == MODE_PUSH_FRONT) begin
            mem_we    = 1'b1;
            mem_waddr = prev_front;
          end
        end
      end
      S_FILL: begin
        mem_we = (cnt != cmd_target);
      end
      S_SWAP_A: begin
        mem_we    = (min_addr != max_addr);
        mem_waddr = min_addr;
        mem_wdata = max_val;
      end
      S_SWAP_B: begin
        mem_we    = out_free;
        mem_waddr = max_addr;
        mem_wdata = min_val;
      end
      default: ;
    endcase
  end

  dqmm_ram #(
    .DEPTH (DEPTH),
    .WIDTH (DATA_W)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      front         <= '0;
      cnt           <= '0;
      m_axis_tvalid <= 1'b0;
      data_vld      <= 1'b0;
    end else begin
      // drain the result register; a load below overrides
      if (m_axis_tvalid && m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (accept) begin
            cmd_mode   <= s_axis_tuser;
            cmd_value  <= s_axis_tdata[DATA_W-1:0];
            cmd_target <= s_axis_tdata[DATA_W +: CNT_W];
            state      <= S_EXEC;
          end
        end

        S_EXEC: begin
          // hold here until the result register is free; nothing commits before
          if (out_free) begin
            state         <= S_IDLE;
            m_axis_tvalid <= 1'b1;
            out_value     <= '0;
            out_status    <= ST_OK;
            out_count     <= cnt;
            unique case (cmd_mode)
              MODE_PUSH_BACK: begin
                if (is_full) begin
                  out_status <= ST_FULL;
                end else begin
                  cnt       <= cnt + CNT_ONE;
                  out_count <= cnt + CNT_ONE;
                end
              end
              MODE_PUSH_FRONT: begin
                if (is_full) begin
                  out_status <= ST_FULL;
                end else begin
                  front     <= prev_front;
                  cnt       <= cnt + CNT_ONE;
                  out_count <= cnt + CNT_ONE;
                end
              end
              MODE_POP_BACK: begin
                if (is_empty) begin
                  out_status <= ST_EMPTY;
                end else begin
                  out_value <= rd_data;
                  cnt       <= cnt - CNT_ONE;
                  out_count <= cnt - CNT_ONE;
                end
              end
              MODE_POP_FRONT: begin
                if (is_empty) begin
                  out_status <= ST_EMPTY;
                end else begin
                  out_value <= rd_data;
                  front     <= next_front;
                  cnt       <= cnt - CNT_ONE;
                  out_count <= cnt - CNT_ONE;
                end
              end
              MODE_PEEK_FRONT, MODE_PEEK_BACK: begin
                if (is_empty) begin
                  out_status <= ST_EMPTY;
                end else begin
                  out_value <= rd_data;
                end
              end
              MODE_SWAP: begin
                if (!is_empty) begin
                  // no result yet: scan the queue front to back
                  m_axis_tvalid <= 1'b0;
                  state         <= S_SCAN;
                  issue_addr    <= front;
                  issue_left    <= cnt;
                  data_vld      <= 1'b0;
                  first         <= 1'b1;
                end
              end
              MODE_CLEAR: begin
                cnt       <= '0;
                front     <= '0;
                out_count <= '0;
              end
              MODE_RESIZE: begin
                if (cmd_target > CNT_DEPTH) begin
                  out_status <= ST_FULL;
                end else if (cmd_target <= cnt) begin
                  // shrink: advance the front past the dropped items
                  front     <= wrap_add(front, drop);
                  cnt       <= cmd_target;
                  out_count <= cmd_target;
                end else begin
                  m_axis_tvalid <= 1'b0;
                  state         <= S_FILL;
                end
              end
              default: ;
            endcase
          end
        end

        S_FILL: begin
          // append the fill value at the back, one write per cycle
          if (cnt == cmd_target) begin
            if (out_free) begin
              m_axis_tvalid <= 1'b1;
              out_value     <= '0;
              out_status    <= ST_OK;
              out_count     <= cnt;
              state         <= S_IDLE;
            end
          end else begin
            cnt <= cnt + CNT_ONE;
          end
        end

        S_SCAN: begin
          if (issue_left != '0) begin
            issue_addr <= inc_idx(issue_addr);
            issue_left <= issue_left - CNT_ONE;
            data_addr  <= issue_addr;
            data_vld   <= 1'b1;
          end else begin
            data_vld <= 1'b0;
          end
          if (data_vld) begin
            first <= 1'b0;
            if (first) begin
              min_val  <= $signed(rd_data);
              max_val  <= $signed(rd_data);
              min_addr <= data_addr;
              max_addr <= data_addr;
            end else begin
              // strict compares keep the first-found extreme
              if ($signed(rd_data) < min_val) begin
                min_val  <= $signed(rd_data);
                min_addr <= data_addr;
              end
              if (max_val < $signed(rd_data)) begin
                max_val  <= $signed(rd_data);
                max_addr <= data_addr;
              end
            end
            // reads are issued back to back, so data with nothing left to
            // issue is the last item
            if (issue_left == '0) begin
              state <= S_SWAP_A;
            end
          end
        end

        S_SWAP_A: begin
          if (min_addr == max_addr) begin
            if (out_free) begin
              m_axis_tvalid <= 1'b1;
              out_value     <= '0;
              out_status    <= ST_OK;
              out_count     <= cnt;
              state         <= S_IDLE;
            end
          end else begin
            state <= S_SWAP_B;
          end
        end

        S_SWAP_B: begin
          if (out_free) begin
            m_axis_tvalid <= 1'b1;
            out_value     <= '0;
            out_status    <= ST_OK;
            out_count     <= cnt;
            state         <= S_IDLE;
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

  always_comb begin
    m_axis_tdata                   = '0;
    m_axis_tdata[DATA_W-1:0]       = out_value;
    m_axis_tdata[DATA_W +: CNT_W]  = out_count;
  end

  assign m_axis_tuser = out_status;

endmodule

>>> rtl/dqmm_ram.sv
// ----------------------------------------------------------------------------
// dqmm_ram
// Simple dual-port ring store: one write port, one read port, registered
// read data. Read data holds when no read is issued.
// ----------------------------------------------------------------------------
module dqmm_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 32,
  localparam int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> rtl/dqmm_check.sv
// ----------------------------------------------------------------------------
// dqmm_check
// Port-level checks for the deque block, bound to the top level.
// ----------------------------------------------------------------------------
module dqmm_check
  import dqmm_pkg::*;
#(
  parameter int DEPTH = 64,
  localparam int CNT_W = $clog2(DEPTH + 1),
  localparam int OUT_W = ((DATA_W + CNT_W + 7) / 8) * 8
) (
  input logic                clk,
  input logic                rst,
  input logic                s_axis_tvalid,
  input logic                s_axis_tready,
  input logic                m_axis_tvalid,
  input logic                m_axis_tready,
  input logic [OUT_W-1:0]    m_axis_tdata,
  input logic [STATUS_W-1:0] m_axis_tuser
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result changed while stalled");

  // no result is left over from before reset
  a_reset_idle: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("result valid right after reset");

  // count never exceeds capacity
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tdata[DATA_W +: CNT_W] <= CNT_W'(DEPTH))
    else $error("item count beyond capacity");

  // an empty report comes with an empty queue and a zero value
  a_empty_result: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && (m_axis_tuser == ST_EMPTY) |->
      (m_axis_tdata[DATA_W +: CNT_W] == '0) && (m_axis_tdata[DATA_W-1:0] == '0))
    else $error("empty status with items or a value");

  // one command at a time: the input closes right after a transfer
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("command taken while another is in flight");

endmodule

bind deque_with_min_max_swap_top dqmm_check #(.DEPTH(DEPTH)) u_dqmm_check (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);
